FILE: hdl/ptr_pkg.sv
`timescale 1ns / 1ps
// Shared constants and codes for the prism-to-triangle rebuild block.
// Used by prism_to_triangle_rebuild; depends on nothing.
package ptr_pkg;

  localparam int NORM_PACK_W = 48;
  localparam int MIN_SCALE_W = 21;
  localparam int CFG_DATA_W = 24;
  localparam logic [MIN_SCALE_W-1:0] MIN_SCALE_RESET = 21'd1;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_DEGEN = 2'd1,
    ST_OVFL  = 2'd2
  } status_t;

endpackage

FILE: hdl/prism_to_triangle_rebuild.sv
`timescale 1ns / 1ps
// Top level of the prism-to-triangle rebuild: cross products, dot products,
// pipelined restoring dividers and saturation. Depends on ptr_pkg.
//
// Takes one prism record per cycle while the output is not stalled and returns
// one triangle per record, in order. The six restoring dividers resolve one
// quotient bit per stage. A stalled output holds the whole pipeline. The
// min_scale register is written through the always-ready cfg channel; the user
// must do so only while the block is idle, which the block does not enforce.
module prism_to_triangle_rebuild #(
  parameter int COORD_BITS = 32,
  parameter int NORMAL_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // base_x, base_y, base_z, face_normal, edge0_normal, edge1_normal,
  // edge2_normal, height, zero fill
  input  logic [((4*COORD_BITS+4*ptr_pkg::NORM_PACK_W+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // vert_a_x..z, vert_b_x..z, vert_c_x..z, tri_normal, zero fill
  output logic [((9*COORD_BITS+ptr_pkg::NORM_PACK_W+7)/8)*8-1:0] out_tdata,
  // status
  output logic [1:0] out_tuser,
  input  logic cfg_tvalid,
  output logic cfg_tready,
  // min_scale, zero fill
  input  logic [ptr_pkg::CFG_DATA_W-1:0] cfg_tdata
);

  localparam int CB = COORD_BITS;
  localparam int NB = NORMAL_BITS;
  localparam int NPW = ptr_pkg::NORM_PACK_W;
  localparam int MSW = ptr_pkg::MIN_SCALE_W;
  localparam int FR = NB - 2;
  localparam int PW2 = 2 * NB;
  localparam int XW = 2 * NB + 1;
  localparam int TW = 3 * NB + 1;
  localparam int DM = 3 * NB;
  localparam int PW = 2 * NB + CB;
  localparam int NW = PW + FR;
  localparam int QB = CB + 1;
  localparam int MW = (DM > MSW) ? DM : MSW;
  localparam int SW = CB + 3;
  localparam int OW = $bits(out_tdata);

  localparam logic signed [SW-1:0] CMAX = SW'(signed'((65'sd1 <<< (CB - 1)) - 65'sd1));
  localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

  logic [MSW-1:0] min_scale_r;
  logic en;

  assign cfg_tready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_scale_r <= ptr_pkg::MIN_SCALE_RESET;
    end else if (cfg_tvalid) begin
      min_scale_r <= cfg_tdata[MSW-1:0];
    end
  end

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // Input unpacking.
  logic signed [CB-1:0] i_base [3];
  logic signed [NB-1:0] i_f [3];
  logic signed [NB-1:0] i_e0 [3];
  logic signed [NB-1:0] i_e1 [3];
  logic signed [NB-1:0] i_e2 [3];
  logic signed [CB-1:0] i_h;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      i_base[k] = in_tdata[k*CB +: CB];
      i_f[k]  = in_tdata[3*CB + k*NB +: NB];
      i_e0[k] = in_tdata[3*CB + NPW + k*NB +: NB];
      i_e1[k] = in_tdata[3*CB + 2*NPW + k*NB +: NB];
      i_e2[k] = in_tdata[3*CB + 3*NPW + k*NB +: NB];
    end
    i_h = in_tdata[3*CB + 4*NPW +: CB];
  end

  // Stage A: partial products of the two cross products.
  logic a_v_r;
  logic signed [PW2-1:0] a_p_r [12];
  logic signed [CB-1:0] a_base_r [3];
  logic signed [NB-1:0] a_e2_r [3];
  logic signed [CB-1:0] a_h_r;
  logic [NPW-1:0] a_face_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p_r[0]  <= i_f[1] * i_e1[2];
      a_p_r[1]  <= i_f[2] * i_e1[1];
      a_p_r[2]  <= i_f[2] * i_e1[0];
      a_p_r[3]  <= i_f[0] * i_e1[2];
      a_p_r[4]  <= i_f[0] * i_e1[1];
      a_p_r[5]  <= i_f[1] * i_e1[0];
      a_p_r[6]  <= i_e0[1] * i_f[2];
      a_p_r[7]  <= i_e0[2] * i_f[1];
      a_p_r[8]  <= i_e0[2] * i_f[0];
      a_p_r[9]  <= i_e0[0] * i_f[2];
      a_p_r[10] <= i_e0[0] * i_f[1];
      a_p_r[11] <= i_e0[1] * i_f[0];
      for (int k = 0; k < 3; k++) begin
        a_base_r[k] <= i_base[k];
        a_e2_r[k] <= i_e2[k];
      end
      a_h_r <= i_h;
      a_face_r <= NPW'(in_tdata[3*CB +: 3*NB]);
    end
  end

  // Stage B: cross components, lanes 0..2 across and 3..5 along.
  logic b_v_r;
  logic signed [XW-1:0] b_x_r [6];
  logic signed [CB-1:0] b_base_r [3];
  logic signed [NB-1:0] b_e2_r [3];
  logic signed [CB-1:0] b_h_r;
  logic [NPW-1:0] b_face_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 6; l++) begin
        b_x_r[l] <= XW'(a_p_r[2*l]) - XW'(a_p_r[2*l+1]);
      end
      b_base_r <= a_base_r;
      b_e2_r <= a_e2_r;
      b_h_r <= a_h_r;
      b_face_r <= a_face_r;
    end
  end

  // Stage C: dot terms and numerator magnitudes.
  logic c_v_r;
  logic signed [TW-1:0] c_t_r [6];
  logic [PW-1:0] c_nm_r [6];
  logic [5:0] c_neg_r;
  logic signed [CB-1:0] c_base_r [3];
  logic [NPW-1:0] c_face_r;
  logic [PW2-1:0] c_xmag [6];
  logic [CB-1:0] c_hmag;

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      c_xmag[l] = b_x_r[l][XW-1] ? PW2'(-b_x_r[l]) : PW2'(b_x_r[l]);
    end
    c_hmag = b_h_r[CB-1] ? CB'(-b_h_r) : CB'(b_h_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 6; l++) begin
        c_t_r[l] <= TW'(b_x_r[l]) * TW'(b_e2_r[l % 3]);
        c_nm_r[l] <= PW'(c_xmag[l]) * PW'(c_hmag);
        c_neg_r[l] <= b_x_r[l][XW-1] ^ b_h_r[CB-1];
      end
      c_base_r <= b_base_r;
      c_face_r <= b_face_r;
    end
  end

  // Stage D: dot products and the degenerate test.
  logic d_v_r;
  logic [DM-1:0] d_dm_r [6];
  logic [NW-1:0] d_num_r [6];
  logic [5:0] d_neg_r;
  logic d_degen_r;
  logic signed [CB-1:0] d_base_r [3];
  logic [NPW-1:0] d_face_r;
  logic signed [TW-1:0] d_dot [2];
  logic [DM-1:0] d_dmag [2];
  logic [1:0] d_small;

  always_comb begin
    for (int g = 0; g < 2; g++) begin
      d_dot[g] = c_t_r[3*g] + c_t_r[3*g+1] + c_t_r[3*g+2];
      d_dmag[g] = d_dot[g][TW-1] ? DM'(-d_dot[g]) : DM'(d_dot[g]);
      d_small[g] = (d_dmag[g] == '0) || (MW'(d_dmag[g]) < MW'(min_scale_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 6; l++) begin
        d_dm_r[l] <= d_dmag[l / 3];
        d_num_r[l] <= {c_nm_r[l], {FR{1'b0}}};
        d_neg_r[l] <= c_neg_r[l] ^ d_dot[l / 3][TW-1];
      end
      d_degen_r <= |d_small;
      d_base_r <= c_base_r;
      d_face_r <= c_face_r;
    end
  end

  // Divider pipeline: entry 0 holds the high part test, then one bit per stage.
  logic q_v_r [QB+1];
  logic [DM-1:0] q_rem_r [QB+1][6];
  logic [DM-1:0] q_d_r [QB+1][6];
  logic [NW-1:0] q_num_r [QB+1][6];
  logic [QB-1:0] q_q_r [QB+1][6];
  logic [5:0] q_neg_r [QB+1];
  logic [5:0] q_ovf_r [QB+1];
  logic q_degen_r [QB+1];
  logic signed [CB-1:0] q_base_r [QB+1][3];
  logic [NPW-1:0] q_face_r [QB+1];
  logic [DM-1:0] e_r0 [6];
  logic [5:0] e_big;
  logic [DM:0] s_rem2 [QB][6];
  logic s_ge [QB][6];

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      e_r0[l] = DM'(d_num_r[l][NW-1:QB]);
      e_big[l] = e_r0[l] >= d_dm_r[l];
    end
    for (int j = 1; j <= QB; j++) begin
      for (int l = 0; l < 6; l++) begin
        s_rem2[j-1][l] = {q_rem_r[j-1][l], q_num_r[j-1][l][QB-j]};
        s_ge[j-1][l] = s_rem2[j-1][l] >= {1'b0, q_d_r[j-1][l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QB; j++) begin
        q_v_r[j] <= 1'b0;
      end
    end else if (en) begin
      q_v_r[0] <= d_v_r;
      for (int j = 1; j <= QB; j++) begin
        q_v_r[j] <= q_v_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 6; l++) begin
        q_rem_r[0][l] <= e_big[l] ? '0 : e_r0[l];
        q_d_r[0][l] <= d_dm_r[l];
        q_num_r[0][l] <= d_num_r[l];
        q_q_r[0][l] <= '0;
      end
      q_neg_r[0] <= d_neg_r;
      q_ovf_r[0] <= e_big;
      q_degen_r[0] <= d_degen_r;
      q_base_r[0] <= d_base_r;
      q_face_r[0] <= d_face_r;
      for (int j = 1; j <= QB; j++) begin
        for (int l = 0; l < 6; l++) begin
          q_rem_r[j][l] <= s_ge[j-1][l] ? DM'(s_rem2[j-1][l] - {1'b0, q_d_r[j-1][l]})
                                        : DM'(s_rem2[j-1][l]);
          q_d_r[j][l] <= q_d_r[j-1][l];
          q_num_r[j][l] <= q_num_r[j-1][l];
          q_q_r[j][l] <= q_q_r[j-1][l] | (QB'(s_ge[j-1][l]) << (QB - j));
        end
        q_neg_r[j] <= q_neg_r[j-1];
        q_ovf_r[j] <= q_ovf_r[j-1];
        q_degen_r[j] <= q_degen_r[j-1];
        q_base_r[j] <= q_base_r[j-1];
        q_face_r[j] <= q_face_r[j-1];
      end
    end
  end

  // Output stage: offset, add, saturate, status.
  logic signed [SW-1:0] f_off [6];
  logic signed [SW-1:0] f_sum [6];
  logic signed [SW-1:0] f_res [6];
  logic [5:0] f_ovf;
  logic [OW-1:0] f_data;
  ptr_pkg::status_t f_status;
  logic [OW-1:0] out_data_r;
  ptr_pkg::status_t out_status_r;
  logic out_v_r;

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      f_off[l] = q_neg_r[QB][l] ? -SW'(q_q_r[QB][l]) : SW'(q_q_r[QB][l]);
      f_sum[l] = SW'(q_base_r[QB][l % 3]) + f_off[l];
      if (q_ovf_r[QB][l]) begin
        f_res[l] = q_neg_r[QB][l] ? CMIN : CMAX;
        f_ovf[l] = 1'b1;
      end else if (f_sum[l] > CMAX) begin
        f_res[l] = CMAX;
        f_ovf[l] = 1'b1;
      end else if (f_sum[l] < CMIN) begin
        f_res[l] = CMIN;
        f_ovf[l] = 1'b1;
      end else begin
        f_res[l] = f_sum[l];
        f_ovf[l] = 1'b0;
      end
    end
    f_data = '0;
    for (int k = 0; k < 3; k++) begin
      f_data[k*CB +: CB] = q_base_r[QB][k];
      f_data[(3+k)*CB +: CB] = q_degen_r[QB] ? '0 : f_res[k][CB-1:0];
      f_data[(6+k)*CB +: CB] = q_degen_r[QB] ? '0 : f_res[3+k][CB-1:0];
    end
    f_data[9*CB +: NPW] = q_face_r[QB];
    if (q_degen_r[QB]) begin
      f_status = ptr_pkg::ST_DEGEN;
    end else if (|f_ovf) begin
      f_status = ptr_pkg::ST_OVFL;
    end else begin
      f_status = ptr_pkg::ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= q_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= f_data;
      out_status_r <= f_status;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_status_r;

endmodule
